// ===== rtl/core/crt_pkg.sv =====
// Shared types and constants of the clip rectangle table.
`default_nettype none

package crt_pkg;

    localparam int COORD_W = 24;
    localparam int EDGE_W  = COORD_W + 2;

    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_APPEND    = 3'd1;
    localparam logic [2:0] OP_INFINITE  = 3'd2;
    localparam logic [2:0] OP_TRANSLATE = 3'd3;
    localparam logic [2:0] OP_TEST      = 3'd4;

    localparam logic signed [COORD_W-1:0] INF_ORIGIN = 24'shC00000;
    localparam logic [COORD_W-1:0]        INF_SIZE   = 24'h800000;
    localparam logic signed [COORD_W-1:0] COORD_MIN  = 24'sh800000;
    localparam logic signed [COORD_W-1:0] COORD_MAX  = 24'sh7FFFFF;
    localparam logic [COORD_W-1:0]        SPAN_MAX   = 24'hFFFFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [COORD_W-1:0]        wide;
        logic [COORD_W-1:0]        tall;
    } rect_t;

    // control from the sequencer to the scan datapath
    typedef struct packed {
        logic start;
        logic rd_valid;
        logic first;
        logic translate;
    } crt_scan_ctl_t;

    typedef struct packed {
        logic                      busy;
        logic                      hit_any;
        logic                      inf_first;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic [COORD_W-1:0]        bw;
        logic [COORD_W-1:0]        bh;
    } crt_scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/crt_rect_mem.sv =====
// Rectangle table storage: one write port, one registered read port.
`default_nettype none

module crt_rect_mem
    import crt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire rect_t         wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output rect_t              rd_data
);

    rect_t mem [DEPTH];
    rect_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crt_scan.sv =====
// Per-entry datapath: translate with write-back, hit test, bounding box accumulation.
`default_nettype none

module crt_scan
    import crt_pkg::*;
#(
    parameter int AW = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire crt_scan_ctl_t             ctl,
    input  wire logic [AW-1:0]             rd_addr,
    input  wire rect_t                     entry,
    input  wire logic signed [COORD_W-1:0] dx,
    input  wire logic signed [COORD_W-1:0] dy,
    output logic                           wb_en,
    output logic [AW-1:0]                  wb_addr,
    output rect_t                          wb_data,
    output crt_scan_res_t                  res
);

    // stage 1: translated entry
    logic                     vld1_reg;
    logic                     first1_reg;
    logic [AW-1:0]            addr1_reg;
    rect_t                    ent1_reg;
    logic signed [COORD_W:0]  sum_x;
    logic signed [COORD_W:0]  sum_y;
    rect_t                    ent1_next;

    // stage 2: edges and hit
    logic                     vld2_reg;
    logic                     first2_reg;
    logic                     hit2_reg;
    logic                     inf2_reg;
    logic signed [EDGE_W-1:0] l2_reg, t2_reg, r2_reg, b2_reg;
    logic signed [EDGE_W-1:0] l1_ext, t1_ext, r1_ext, b1_ext, px_ext, py_ext;

    // stage 3: accumulators
    logic signed [EDGE_W-1:0] nx_reg, ny_reg, fx_reg, fy_reg;
    logic                     hit_reg;
    logic                     inf_reg;

    logic signed [EDGE_W:0]   span_w, span_h;

    always_comb begin
        sum_x = {entry.left[COORD_W-1], entry.left} + {dx[COORD_W-1], dx};
        sum_y = {entry.top[COORD_W-1], entry.top} + {dy[COORD_W-1], dy};
        ent1_next = entry;
        if (ctl.translate) begin
            if (sum_x[COORD_W] != sum_x[COORD_W-1]) begin
                ent1_next.left = sum_x[COORD_W] ? COORD_MIN : COORD_MAX;
            end else begin
                ent1_next.left = sum_x[COORD_W-1:0];
            end
            if (sum_y[COORD_W] != sum_y[COORD_W-1]) begin
                ent1_next.top = sum_y[COORD_W] ? COORD_MIN : COORD_MAX;
            end else begin
                ent1_next.top = sum_y[COORD_W-1:0];
            end
        end
    end

    always_comb begin
        l1_ext = EDGE_W'(ent1_reg.left);
        t1_ext = EDGE_W'(ent1_reg.top);
        r1_ext = l1_ext + $signed({2'b00, ent1_reg.wide});
        b1_ext = t1_ext + $signed({2'b00, ent1_reg.tall});
        px_ext = EDGE_W'(dx);
        py_ext = EDGE_W'(dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            vld1_reg <= ctl.rd_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        first1_reg <= ctl.first;
        addr1_reg  <= rd_addr;
        ent1_reg   <= ent1_next;

        first2_reg <= first1_reg;
        l2_reg     <= l1_ext;
        t2_reg     <= t1_ext;
        r2_reg     <= r1_ext;
        b2_reg     <= b1_ext;
        hit2_reg   <= (px_ext >= l1_ext) && (px_ext < r1_ext) &&
                      (py_ext >= t1_ext) && (py_ext < b1_ext);
        inf2_reg   <= (ent1_reg.left == INF_ORIGIN) && (ent1_reg.top == INF_ORIGIN) &&
                      (ent1_reg.wide == INF_SIZE) && (ent1_reg.tall == INF_SIZE);

        if (ctl.start) begin
            hit_reg <= 1'b0;
        end else if (vld2_reg && hit2_reg) begin
            hit_reg <= 1'b1;
        end

        if (vld2_reg) begin
            if (first2_reg) begin
                nx_reg  <= l2_reg;
                ny_reg  <= t2_reg;
                fx_reg  <= r2_reg;
                fy_reg  <= b2_reg;
                inf_reg <= inf2_reg;
            end else begin
                if (l2_reg < nx_reg) nx_reg <= l2_reg;
                if (t2_reg < ny_reg) ny_reg <= t2_reg;
                if (r2_reg > fx_reg) fx_reg <= r2_reg;
                if (b2_reg > fy_reg) fy_reg <= b2_reg;
            end
        end
    end

    assign wb_en   = vld1_reg && ctl.translate;
    assign wb_addr = addr1_reg;
    assign wb_data = ent1_reg;

    always_comb begin
        span_w = (EDGE_W + 1)'(fx_reg) - (EDGE_W + 1)'(nx_reg);
        span_h = (EDGE_W + 1)'(fy_reg) - (EDGE_W + 1)'(ny_reg);
        res.busy      = vld1_reg || vld2_reg;
        res.hit_any   = hit_reg;
        res.inf_first = inf_reg;
        res.bx        = nx_reg[COORD_W-1:0];
        res.by        = ny_reg[COORD_W-1:0];
        if (span_w[EDGE_W]) begin
            res.bw = '0;
        end else if (span_w[EDGE_W-1:COORD_W] != '0) begin
            res.bw = SPAN_MAX;
        end else begin
            res.bw = span_w[COORD_W-1:0];
        end
        if (span_h[EDGE_W]) begin
            res.bh = '0;
        end else if (span_h[EDGE_W-1:COORD_W] != '0) begin
            res.bh = SPAN_MAX;
        end else begin
            res.bh = span_h[COORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/clip_rect_table_hit_test_core.sv =====
// Top level: rectangle table sequencer, memory, scan datapath and result register.
`default_nettype none

// Clip region held as a table of up to DEPTH rectangles in a single memory.
// Each transaction clears, appends, loads the infinite region, translates
// all entries (clamped) or tests a point; every result carries the bounding
// box, empty and infinite flags and the entry count after the operation.
// Every operation rescans the table for the bounding box, one entry per
// cycle through the memory's one read port, followed by a three-stage
// datapath and the result register. A new transaction is taken as soon as
// the previous result has been moved to the output register, even while
// that result is still waiting to be taken.
module clip_rect_table_hit_test_core
    import crt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [2:0]                s_op,
    input  wire logic signed [COORD_W-1:0] s_x,
    input  wire logic signed [COORD_W-1:0] s_y,
    input  wire logic [COORD_W-1:0]        s_width,
    input  wire logic [COORD_W-1:0]        s_height,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_visible,
    output logic                           m_table_full,
    output logic [4:0]                     m_rect_count,
    output logic signed [COORD_W-1:0]      m_bound_x,
    output logic signed [COORD_W-1:0]      m_bound_y,
    output logic [COORD_W-1:0]             m_bound_w,
    output logic [COORD_W-1:0]             m_bound_h,
    output logic                           m_is_empty,
    output logic                           m_is_infinite
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       rd_valid_reg;
    logic                       rd_first_reg;
    logic [AW-1:0]              rd_addr_reg;
    logic [2:0]                 op_reg;
    logic signed [COORD_W-1:0]  px_reg, py_reg;
    logic                       full_reg;
    logic                       m_valid_reg, m_valid_next;

    logic                       m_visible_reg, m_table_full_reg, m_is_empty_reg;
    logic                       m_is_infinite_reg;
    logic [4:0]                 m_rect_count_reg;
    logic signed [COORD_W-1:0]  m_bound_x_reg, m_bound_y_reg;
    logic [COORD_W-1:0]         m_bound_w_reg, m_bound_h_reg;

    logic                       accept;
    logic                       rd_en;
    logic                       load;
    logic                       app_we;
    logic [AW-1:0]              app_addr;
    rect_t                      app_data;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    rect_t                      mem_wdata;
    rect_t                      mem_rdata;
    logic                       wb_en;
    logic [AW-1:0]              wb_addr;
    rect_t                      wb_data;
    crt_scan_ctl_t              scan_ctl;
    crt_scan_res_t              scan_res;
    logic [CW+4:0]              count_ext;
    logic                       scan_done;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign rd_en   = (state_reg == ST_SCAN) && (idx_reg != count_reg);
    assign load    = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign scan_done = (idx_reg == count_reg) && !rd_valid_reg && !scan_res.busy;

    // the one entry written by append or infinite load
    always_comb begin
        app_we   = 1'b0;
        app_addr = '0;
        app_data = '{left: s_x, top: s_y, wide: s_width, tall: s_height};
        if (accept) begin
            case (s_op)
                OP_APPEND: begin
                    app_we   = (count_reg != FULL_COUNT);
                    app_addr = count_reg[AW-1:0];
                end
                OP_INFINITE: begin
                    app_we   = 1'b1;
                    app_data = '{left: INF_ORIGIN, top: INF_ORIGIN,
                                 wide: INF_SIZE, tall: INF_SIZE};
                end
                default: begin
                    app_we = 1'b0;
                end
            endcase
        end
    end

    // append and write-back never coincide: one is in idle, the other mid-scan
    assign mem_we    = app_we || wb_en;
    assign mem_waddr = app_we ? app_addr : wb_addr;
    assign mem_wdata = app_we ? app_data : wb_data;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                    case (s_op)
                        OP_CLEAR:    count_next = '0;
                        OP_APPEND:   count_next = app_we ? count_reg + 1'b1 : count_reg;
                        OP_INFINITE: count_next = CW'(1);
                        default:     count_next = count_reg;
                    endcase
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (scan_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_en;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg <= (idx_reg == '0);
        rd_addr_reg  <= idx_reg[AW-1:0];
        if (accept) begin
            op_reg   <= s_op;
            px_reg   <= s_x;
            py_reg   <= s_y;
            full_reg <= (s_op == OP_APPEND) && (count_reg == FULL_COUNT);
        end
    end

    assign count_ext = {5'b0, count_reg};

    always_ff @(posedge aclk) begin
        if (load) begin
            m_visible_reg     <= (op_reg == OP_TEST) && scan_res.hit_any;
            m_table_full_reg  <= full_reg;
            m_rect_count_reg  <= count_ext[4:0];
            m_is_infinite_reg <= (count_reg == CW'(1)) && scan_res.inf_first;
            if (count_reg == '0) begin
                m_bound_x_reg  <= '0;
                m_bound_y_reg  <= '0;
                m_bound_w_reg  <= '0;
                m_bound_h_reg  <= '0;
                m_is_empty_reg <= 1'b1;
            end else begin
                m_bound_x_reg  <= scan_res.bx;
                m_bound_y_reg  <= scan_res.by;
                m_bound_w_reg  <= scan_res.bw;
                m_bound_h_reg  <= scan_res.bh;
                m_is_empty_reg <= (scan_res.bw == '0) || (scan_res.bh == '0);
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_visible     = m_visible_reg;
    assign m_table_full  = m_table_full_reg;
    assign m_rect_count  = m_rect_count_reg;
    assign m_bound_x     = m_bound_x_reg;
    assign m_bound_y     = m_bound_y_reg;
    assign m_bound_w     = m_bound_w_reg;
    assign m_bound_h     = m_bound_h_reg;
    assign m_is_empty    = m_is_empty_reg;
    assign m_is_infinite = m_is_infinite_reg;

    assign scan_ctl = '{start: accept, rd_valid: rd_valid_reg, first: rd_first_reg,
                        translate: (op_reg == OP_TRANSLATE)};

    crt_rect_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    crt_scan #(
        .AW (AW)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .rd_addr (rd_addr_reg),
        .entry   (mem_rdata),
        .dx      (px_reg),
        .dy      (py_reg),
        .wb_en   (wb_en),
        .wb_addr (wb_addr),
        .wb_data (wb_data),
        .res     (scan_res)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    a_read_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> idx_reg < count_reg)
        else $error("read beyond stored entries");

    a_wb_translate: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_en |-> (op_reg == OP_TRANSLATE) && (state_reg == ST_SCAN))
        else $error("write-back outside a translate scan");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> m_rect_count == 5'(DEPTH))
        else $error("refused append while table not full");

    a_inf_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_infinite |-> (m_rect_count == 5'd1) && !m_is_empty)
        else $error("infinite flag with inconsistent status");
`endif

endmodule

`default_nettype wire
